/* rtl/pdcm_pkg.sv */
// ----------------------------------------------------------------------------
// pdcm_pkg
// Shared types, widths and constants of the PWM duty channel manager.
// ----------------------------------------------------------------------------
`default_nettype none

package pdcm_pkg;

  localparam int unsigned NUM_CHANNELS_DEF = 4;
  localparam int unsigned MATCH_MAX        = 4;   // channels that can own a pin

  localparam int unsigned RES_W    = 5;
  localparam int unsigned TOP_W    = 15;
  localparam int unsigned MAP_W    = 32;
  localparam int unsigned PIN_W    = 8;
  localparam int unsigned DUTY_W   = 32;
  localparam int unsigned SCALE_W  = 16;          // full-scale duty width
  localparam int unsigned NUM_W    = 32;          // scaled numerator width
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [RES_W-1:0] RES_MIN   = 5'd1;
  localparam logic [RES_W-1:0] RES_MAX   = 5'd16;
  localparam logic [RES_W-1:0] RES_RESET = 5'd8;
  localparam logic [TOP_W-1:0] TOP_RESET = 15'd16000;
  localparam logic [MAP_W-1:0] MAP_RESET = 32'h0908_0706;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_RES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTER_TOP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIN_MAP     = 2'd2;

  // Request kinds
  localparam logic KIND_SET     = 1'b0;
  localparam logic KIND_DISABLE = 1'b1;

  typedef struct packed {
    logic                     kind;
    logic [PIN_W-1:0]         pin_number;
    logic signed [DUTY_W-1:0] duty_value;
  } pdcm_in_t;

  typedef struct packed {
    logic             digital_write;
    logic             digital_level;
    logic             channel_hit;
    logic [1:0]       channel_index;
    logic [TOP_W-1:0] channel_pulse;
    logic [3:0]       used_mask;
    logic             generator_running;
    logic [3:0]       static_levels;
  } pdcm_out_t;

endpackage

`default_nettype wire

/* rtl/pwm_duty_channel_manager.sv */
// ----------------------------------------------------------------------------
// pwm_duty_channel_manager
// Duty requests for a small bank of PWM channels, with rounded scaling.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : in_valid_i / in_ready_o carry one request word (kind, pin,
//                 duty). A set-duty word on an owned pin scales the clamped
//                 duty to a compare value; a disable word frees the channel.
//   out channel : out_valid_o / out_ready_i carry one result word per request.
//   cfg port    : cfg_we_i, cfg_index_i, cfg_wdata_i; write only while idle.
// Sequence: a set-duty word that needs scaling passes the multiply, divide,
//   apply and finish steps, with one divider hand-over between divide and
//   apply; every other word goes straight to apply and finish.
//   The bit-serial divider is used once per scaled request; the block takes
//   one word at a time and is not ready while working, so it cannot take a
//   new word before it is through with the last one.
// Reset: all channels free, pulses zero, generator stopped, registers at their
//   reset values; no result pending.
// Stall: the result sits in an output register; a new word is taken while it
//   waits, and that word holds in its finish step until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module pwm_duty_channel_manager #(
  parameter int unsigned NUM_CHANNELS = pdcm_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [pdcm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [pdcm_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire pdcm_pkg::pdcm_in_t                 in_word_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output pdcm_pkg::pdcm_out_t                     out_word_o
);

  localparam int unsigned CHW     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned MATCH_N = (NUM_CHANNELS < pdcm_pkg::MATCH_MAX) ?
                                    NUM_CHANNELS : pdcm_pkg::MATCH_MAX;
  localparam int unsigned TOP_W   = pdcm_pkg::TOP_W;
  localparam int unsigned SCALE_W = pdcm_pkg::SCALE_W;
  localparam int unsigned NUM_W   = pdcm_pkg::NUM_W;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_MUL    = 5'b00010,
    S_DIV    = 5'b00100,
    S_APPLY  = 5'b01000,
    S_FINISH = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [pdcm_pkg::RES_W-1:0] write_res_q;
  logic [TOP_W-1:0]           top_q;
  logic [pdcm_pkg::MAP_W-1:0] pin_map_q;

  // channel state
  logic [NUM_CHANNELS-1:0] used_q, used_d;
  logic [TOP_W-1:0]        pulse_q [NUM_CHANNELS];
  logic [TOP_W-1:0]        pulse_d [NUM_CHANNELS];
  logic                    running_q, running_d;

  // request held over the sequence
  logic               kind_q, hit_q, dig_q, lvl_q, recalc_q, recalc_d;
  logic [CHW-1:0]     ch_q;
  logic [SCALE_W-1:0] val_q, maxv_q;
  logic [TOP_W-1:0]   new_pulse_q, new_pulse_d;

  // result register
  logic                out_valid_q, out_valid_d;
  pdcm_pkg::pdcm_out_t out_word_q, out_word_d;

  // front-end decode of the incoming word
  logic [pdcm_pkg::RES_W-1:0] res_eff;
  logic [SCALE_W-1:0]         maxv_in, val_in;
  logic                       hit_in;
  logic [CHW-1:0]             ch_in;
  logic                       accept;

  // shared divider
  logic             div_start, div_done;
  logic [NUM_W-1:0] div_num, div_quo;

  // finish-step helpers
  logic                    any_dyn, run_next, load_out;
  logic [NUM_CHANNELS-1:0] static_vec;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    res_eff = write_res_q;
    if (write_res_q < pdcm_pkg::RES_MIN) res_eff = pdcm_pkg::RES_MIN;
    if (write_res_q > pdcm_pkg::RES_MAX) res_eff = pdcm_pkg::RES_MAX;
    maxv_in = SCALE_W'((32'd1 << res_eff) - 32'd1);
    // clamp: negative to zero, above full scale to full scale
    if (in_word_i.duty_value[pdcm_pkg::DUTY_W-1]) begin
      val_in = '0;
    end else if (in_word_i.duty_value > $signed({16'd0, maxv_in})) begin
      val_in = maxv_in;
    end else begin
      val_in = in_word_i.duty_value[SCALE_W-1:0];
    end
    // lowest-numbered channel wins on duplicate pins
    hit_in = 1'b0;
    ch_in  = '0;
    for (int c = MATCH_N - 1; c >= 0; c--) begin
      if (pin_map_q[8*c +: 8] == in_word_i.pin_number) begin
        hit_in = 1'b1;
        ch_in  = CHW'(c);
      end
    end
  end

  // numerator of the rounded scaling: val * top + full_scale / 2
  assign div_num   = NUM_W'(val_q) * NUM_W'(top_q) + NUM_W'(maxv_q >> 1);
  assign div_start = (state_q == S_MUL);

  pdcm_div #(
    .DIVIDEND_W(NUM_W),
    .DIVISOR_W (SCALE_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_num),
    .divisor_i (maxv_q),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  always_comb begin
    any_dyn = 1'b0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (used_q[c] && pulse_q[c] != '0 && pulse_q[c] != top_q) any_dyn = 1'b1;
    end
    run_next = recalc_q ? any_dyn : running_q;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      static_vec[c] = used_q[c] && !run_next && (pulse_q[c] >= top_q);
    end
  end

  assign load_out = (state_q == S_FINISH) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    pulse_d     = pulse_q;
    running_d   = running_q;
    recalc_d    = recalc_q;
    new_pulse_d = new_pulse_q;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          new_pulse_d = '0;
          // only a non-zero duty on an owned pin needs the divider
          if (in_word_i.kind == pdcm_pkg::KIND_SET && hit_in && val_in != '0) begin
            state_d = S_MUL;
          end else begin
            state_d = S_APPLY;
          end
        end
      end
      S_MUL: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          // cap the rounded quotient at the counter top
          new_pulse_d = (div_quo > NUM_W'(top_q)) ? top_q : div_quo[TOP_W-1:0];
          state_d     = S_APPLY;
        end
      end
      S_APPLY: begin
        recalc_d = 1'b0;
        if (kind_q == pdcm_pkg::KIND_SET && hit_q) begin
          used_d[ch_q]  = 1'b1;
          pulse_d[ch_q] = new_pulse_q;
          recalc_d      = 1'b1;
        end else if (kind_q == pdcm_pkg::KIND_DISABLE && hit_q && used_q[ch_q]) begin
          used_d[ch_q]  = 1'b0;
          pulse_d[ch_q] = '0;
          recalc_d      = 1'b1;
        end
        state_d = S_FINISH;
      end
      S_FINISH: begin
        // hold here until the result register is free
        if (load_out) begin
          running_d                    = run_next;
          out_valid_d                  = 1'b1;
          out_word_d.digital_write     = dig_q;
          out_word_d.digital_level     = lvl_q;
          out_word_d.channel_hit       = hit_q;
          out_word_d.channel_index     = 2'(ch_q);
          out_word_d.channel_pulse     = hit_q ? pulse_q[ch_q] : '0;
          out_word_d.used_mask         = 4'(used_q);
          out_word_d.generator_running = run_next;
          out_word_d.static_levels     = 4'(static_vec);
          state_d                      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      write_res_q <= pdcm_pkg::RES_RESET;
      top_q       <= pdcm_pkg::TOP_RESET;
      pin_map_q   <= pdcm_pkg::MAP_RESET;
      used_q      <= '0;
      running_q   <= 1'b0;
      out_valid_q <= 1'b0;
      recalc_q    <= 1'b0;
      for (int c = 0; c < NUM_CHANNELS; c++) pulse_q[c] <= '0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      pulse_q     <= pulse_d;
      running_q   <= running_d;
      out_valid_q <= out_valid_d;
      recalc_q    <= recalc_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          pdcm_pkg::REG_WRITE_RES:   write_res_q <= cfg_wdata_i[pdcm_pkg::RES_W-1:0];
          pdcm_pkg::REG_COUNTER_TOP: top_q       <= cfg_wdata_i[TOP_W-1:0];
          pdcm_pkg::REG_PIN_MAP:     pin_map_q   <= cfg_wdata_i[pdcm_pkg::MAP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers: capture the decoded request on acceptance
  always_ff @(posedge clk_i) begin
    new_pulse_q <= new_pulse_d;
    out_word_q  <= out_word_d;
    if (accept) begin
      kind_q <= in_word_i.kind;
      hit_q  <= hit_in;
      ch_q   <= ch_in;
      val_q  <= val_in;
      maxv_q <= maxv_in;
      dig_q  <= (in_word_i.kind == pdcm_pkg::KIND_SET) && !hit_in;
      lvl_q  <= (in_word_i.kind == pdcm_pkg::KIND_SET) && !hit_in &&
                (val_in > (maxv_in >> 1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire

/* rtl/pdcm_div.sv */
// ----------------------------------------------------------------------------
// pdcm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pdcm_div #(
  parameter int unsigned DIVIDEND_W = pdcm_pkg::NUM_W,
  parameter int unsigned DIVISOR_W  = pdcm_pkg::SCALE_W
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DIVIDEND_W-1:0] dividend_i,
  input  wire logic [DIVISOR_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [DIVIDEND_W-1:0]      quotient_o
);

  localparam int unsigned CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  dvs_q, dvs_d;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  always_comb begin
    trial  = {rem_q, quo_q[DIVIDEND_W-1]};
    fits   = (trial >= {1'b0, dvs_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DIVIDEND_W - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // shift in the next dividend bit, subtract when it fits
      rem_d = fits ? DIVISOR_W'(trial - {1'b0, dvs_q}) : trial[DIVISOR_W-1:0];
      quo_d = {quo_q[DIVIDEND_W-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

/* rtl/pdcm_checker.sv */
// ----------------------------------------------------------------------------
// pdcm_checker
// Port-level checks of the PWM duty channel manager, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pdcm_checker (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_ready_o,
  input wire logic                 out_valid_o,
  input wire logic                 out_ready_i,
  input wire pdcm_pkg::pdcm_out_t  out_word_o
);

  // one word at a time: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready high the cycle after a word was taken");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_word_o)))
    else $error("stalled result word changed or dropped");

  a_digital_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_word_o.digital_write && out_word_o.channel_hit) &&
                    (out_word_o.digital_write || !out_word_o.digital_level))
    else $error("digital write on a channel pin, or stray level");

  a_static_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_word_o.static_levels & ~out_word_o.used_mask) == 4'd0))
    else $error("static level on a free channel");

  a_static_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.generator_running) |-> (out_word_o.static_levels == 4'd0))
    else $error("static levels while the generator runs");

endmodule

bind pwm_duty_channel_manager pdcm_checker u_pdcm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_word_o (out_word_o)
);

`default_nettype wire

/* bench/pwm_duty_channel_manager_tb.sv */
// ----------------------------------------------------------------------------
// pwm_duty_channel_manager_tb
// Self-checking bench for the four-channel PWM duty manager. It opens with a
// script of directed requests and register writes, then runs random phases
// under changing register settings and handshake pressure. Each result word is
// checked field by field against a behavioural bank model or a hand-typed result.
// ----------------------------------------------------------------------------

module pwm_duty_channel_manager_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pdcm_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned RAND_PHASES     = 12;
  localparam int unsigned WORDS_PER_PHASE = 167;
  localparam int unsigned TAIL_CYCLES     = 50;  // well past the scaling path

  typedef enum int {STALL_NONE, STALL_COIN, STALL_RUNS, STALL_BEAT} stall_mode_e;

  // One line of the directed script: a register write or a request word,
  // optionally with the result typed in by hand.
  typedef struct {
    bit               is_reg;
    logic [1:0]       reg_idx;
    logic [31:0]      reg_data;
    pdcm_in_t         word;
    bit               known;
    pdcm_out_t        want;
  } script_row_t;

  // --------------------------------------------------------------------------
  // Block ports, all driven from time zero
  // --------------------------------------------------------------------------
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  pdcm_in_t              in_word_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b1;
  pdcm_out_t             out_word_o;

  pwm_duty_channel_manager dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  always #4 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Model of the channel bank: register copies and per-channel state
  // --------------------------------------------------------------------------
  logic [RES_W-1:0] reg_res = RES_RESET;
  logic [TOP_W-1:0] reg_top = TOP_RESET;
  logic [MAP_W-1:0] reg_map = MAP_RESET;

  bit               chan_in_use  [4];
  logic [TOP_W-1:0] chan_compare [4];
  bit               gen_on;

  pdcm_out_t   expected_results[$];
  script_row_t script_rows[$];

  int unsigned errors          = 0;
  int unsigned cycle_cnt       = 0;
  int unsigned words_sent      = 0;
  int unsigned disables_sent   = 0;
  int unsigned results_checked = 0;
  int unsigned regs_written    = 0;
  int unsigned digital_seen    = 0;
  int unsigned running_seen    = 0;

  stall_mode_e stall_mode = STALL_NONE;
  int unsigned stall_run  = 0;
  int unsigned stall_tick = 0;
  bit          stall_low  = 1'b0;

  // Full-scale duty for a resolution, with out-of-range settings clamped
  // to 1..16 bits.
  function automatic int unsigned full_scale(logic [RES_W-1:0] r);
    int unsigned bits;
    bits = (r < RES_MIN) ? 1 : (r > RES_MAX) ? 16 : r;
    return (32'd1 << bits) - 1;
  endfunction

  // Apply one request to the modelled bank and form the result word it causes.
  task automatic predict_channel_update(input pdcm_in_t w, output pdcm_out_t r);
    int unsigned     full, val, pick;
    logic [31:0]     raw;
    longint unsigned num, quo;
    logic [TOP_W-1:0] pulse;
    bit              found, refresh;
    r       = '0;
    full    = full_scale(reg_res);
    raw     = w.duty_value;
    refresh = 1'b0;
    found   = 1'b0;
    pick    = 0;
    // Negative duty reads as zero; anything above full scale is held at it.
    if (raw[31]) val = 0;
    else val = (raw > full) ? full : raw;
    // Walk downwards so that the lowest channel owning a duplicate pin wins.
    for (int c = 3; c >= 0; c--) begin
      if (reg_map[8*c +: 8] == w.pin_number) begin
        found = 1'b1;
        pick  = c;
      end
    end
    if (w.kind == KIND_SET) begin
      if (!found) begin
        r.digital_write = 1'b1;
        r.digital_level = (val > full / 2);
      end else begin
        // Round to nearest and cap at the counter top.
        pulse = '0;
        if (val > 0) begin
          num   = longint'(val) * reg_top + full / 2;
          quo   = num / full;
          pulse = (quo > reg_top) ? reg_top : quo[TOP_W-1:0];
        end
        chan_in_use[pick]  = 1'b1;
        chan_compare[pick] = pulse;
        refresh            = 1'b1;
      end
    end else if (found && chan_in_use[pick]) begin
      chan_in_use[pick]  = 1'b0;
      chan_compare[pick] = '0;
      refresh            = 1'b1;
    end
    // The generator flag is only recomputed when a channel was set or freed.
    if (refresh) begin
      gen_on = 1'b0;
      for (int c = 0; c < 4; c++) begin
        if (chan_in_use[c] && chan_compare[c] != 0 && chan_compare[c] != reg_top) gen_on = 1'b1;
      end
    end
    r.channel_hit       = found;
    r.channel_index     = pick[1:0];
    r.channel_pulse     = found ? chan_compare[pick] : '0;
    r.generator_running = gen_on;
    for (int c = 0; c < 4; c++) begin
      if (chan_in_use[c]) begin
        r.used_mask[c] = 1'b1;
        if (!gen_on && chan_compare[c] >= reg_top) r.static_levels[c] = 1'b1;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Checking: compare each accepted result word with the oldest expectation
  // --------------------------------------------------------------------------
  function automatic string show_word(pdcm_out_t o);
    return $sformatf("dw=%0d lvl=%0d hit=%0d idx=%0d pulse=%0d used=%h run=%0d stat=%h",
                     o.digital_write, o.digital_level, o.channel_hit, o.channel_index,
                     o.channel_pulse, o.used_mask, o.generator_running, o.static_levels);
  endfunction

  function automatic void note_error(string msg);
    errors++;
    if (errors <= 10) $display("[%0t] ERROR: %s", $realtime, msg);
  endfunction

  always @(posedge clk_i) begin
    pdcm_out_t want, got;
    string     bad;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = out_word_o;
      if (expected_results.size() == 0) begin
        note_error({"result word with nothing expected: ", show_word(got)});
      end else begin
        want = expected_results.pop_front();
        bad  = "";
        if (got.digital_write !== want.digital_write) bad = {bad, " digital_write"};
        if (got.digital_level !== want.digital_level) bad = {bad, " digital_level"};
        if (got.channel_hit !== want.channel_hit) bad = {bad, " channel_hit"};
        if (got.channel_index !== want.channel_index) bad = {bad, " channel_index"};
        if (got.channel_pulse !== want.channel_pulse) bad = {bad, " channel_pulse"};
        if (got.used_mask !== want.used_mask) bad = {bad, " used_mask"};
        if (got.generator_running !== want.generator_running) bad = {bad, " generator_running"};
        if (got.static_levels !== want.static_levels) bad = {bad, " static_levels"};
        if (bad != "") begin
          note_error({"field mismatch on", bad, "\n  expected ", show_word(want),
                      "\n  actual   ", show_word(got)});
        end
        results_checked++;
        if (got.digital_write) digital_seen++;
        if (got.generator_running) running_seen++;
      end
    end
  end

  // Watchdog: end the run once the cycle limit is reached.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still expected",
               cycle_cnt, expected_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall on a pattern chosen per phase, changed at the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    logic rdy;
    case (stall_mode)
      STALL_NONE: rdy = 1'b1;
      STALL_COIN: rdy = $urandom_range(0, 1);
      STALL_RUNS: begin
        // Alternate long ready and stalled stretches.
        if (stall_run == 0) begin
          stall_run = $urandom_range(1, 24);
          stall_low = ~stall_low;
        end else begin
          stall_run--;
        end
        rdy = !stall_low;
      end
      default: begin
        stall_tick++;
        rdy = (stall_tick % 7) >= 3;
      end
    endcase
    out_ready_i = rdy;
  end

  // --------------------------------------------------------------------------
  // Sender helpers, all entered and left at a falling edge
  // --------------------------------------------------------------------------

  // Hold valid and the word until accepted, then log the expected result.
  task automatic send_word(input pdcm_in_t w, input bit known, input pdcm_out_t want);
    pdcm_out_t pred;
    in_word_i  = w;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_channel_update(w, pred);
    expected_results.push_back(known ? want : pred);
    words_sent++;
    if (w.kind == KIND_DISABLE) disables_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every expected result has been taken.
  task automatic settle_outputs();
    in_valid_i = 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
  endtask

  // Write one register; only called with the block idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      REG_WRITE_RES:   reg_res = data[RES_W-1:0];
      REG_COUNTER_TOP: reg_top = data[TOP_W-1:0];
      REG_PIN_MAP:     reg_map = data;
      default: ;
    endcase
    regs_written++;
  endtask

  // --------------------------------------------------------------------------
  // Script builders for the directed part
  // --------------------------------------------------------------------------
  function automatic pdcm_out_t result_of(bit dw, bit lvl, bit hit, logic [1:0] idx,
                                          logic [TOP_W-1:0] pulse, logic [3:0] used,
                                          bit run, logic [3:0] stat);
    return {dw, lvl, hit, idx, pulse, used, run, stat};
  endfunction

  function automatic void add_req(logic kind, logic [7:0] pin, logic [31:0] duty);
    script_row_t row;
    row = '{is_reg: 1'b0, reg_idx: '0, reg_data: '0, word: {kind, pin, duty},
            known: 1'b0, want: '0};
    script_rows.push_back(row);
  endfunction

  function automatic void add_known(logic kind, logic [7:0] pin, logic [31:0] duty,
                                    pdcm_out_t want);
    script_row_t row;
    row = '{is_reg: 1'b0, reg_idx: '0, reg_data: '0, word: {kind, pin, duty},
            known: 1'b1, want: want};
    script_rows.push_back(row);
  endfunction

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    script_row_t row;
    row = '{is_reg: 1'b1, reg_idx: idx, reg_data: data, word: '0, known: 1'b0, want: '0};
    script_rows.push_back(row);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    pdcm_in_t         w;
    logic [7:0]       pin;
    logic [31:0]      duty, map_new;
    logic [TOP_W-1:0] top_new;
    logic [RES_W-1:0] res_new;
    int unsigned      full, burst_left, gap, gap_max;

    for (int c = 0; c < 4; c++) begin
      chan_in_use[c]  = 1'b0;
      chan_compare[c] = '0;
    end
    gen_on = 1'b0;

    // Reset map: pins 6, 7, 8, 9 on channels 0..3; resolution 8, top 16000.
    // Unowned pins at both ends of the pin range become digital writes.
    add_known(KIND_SET, 8'd0, 32'd0, result_of(1, 0, 0, 0, 0, 4'b0000, 0, 4'b0000));
    add_known(KIND_SET, 8'd255, 32'h7FFF_FFFF, result_of(1, 1, 0, 0, 0, 4'b0000, 0, 4'b0000));
    // Full duty lands exactly on the top: static high, generator stopped.
    add_known(KIND_SET, 8'd6, 32'd255, result_of(0, 0, 1, 0, 16000, 4'b0001, 0, 4'b0001));
    add_known(KIND_DISABLE, 8'd6, 32'd0, result_of(0, 0, 1, 0, 0, 4'b0000, 0, 4'b0000));
    // Most negative duty reads as zero; largest positive is clamped to full scale.
    add_known(KIND_SET, 8'd7, 32'h8000_0000, result_of(0, 0, 1, 1, 0, 4'b0010, 0, 4'b0000));
    add_known(KIND_SET, 8'd8, 32'h7FFF_FFFF, result_of(0, 0, 1, 2, 16000, 4'b0110, 0, 4'b0100));
    add_req(KIND_SET, 8'd9, 32'd128);
    add_req(KIND_SET, 8'd9, 32'd1);
    add_req(KIND_DISABLE, 8'd200, 32'hFFFF_FFFF);   // disable of an unowned pin
    add_req(KIND_DISABLE, 8'd6, 32'd5);             // disable of a free channel
    add_req(KIND_DISABLE, 8'd9, 32'd0);
    // Resolution below range acts as one bit.
    add_reg(REG_WRITE_RES, 32'd0);
    add_req(KIND_SET, 8'd7, 32'd1);
    add_req(KIND_SET, 8'd100, 32'd1);
    // Resolution above range acts as sixteen bits; probe the half-scale edge.
    add_reg(REG_WRITE_RES, 32'd31);
    add_req(KIND_SET, 8'd8, 32'd65535);
    add_req(KIND_SET, 8'd50, 32'd32767);
    add_req(KIND_SET, 8'd50, 32'd32768);
    add_req(KIND_SET, 8'd9, 32'd32768);
    // Tiny counter tops, zero among them.
    add_reg(REG_COUNTER_TOP, 32'd0);
    add_req(KIND_SET, 8'd7, 32'd200);
    add_reg(REG_COUNTER_TOP, 32'd2);
    add_req(KIND_SET, 8'd9, 32'd65535);
    // Largest top with every channel on one pin: channel 0 takes it.
    add_reg(REG_COUNTER_TOP, 32'd32767);
    add_reg(REG_PIN_MAP, 32'h0606_0606);
    add_req(KIND_SET, 8'd6, 32'd30000);
    add_req(KIND_DISABLE, 8'd6, 32'd0);
    add_reg(REG_PIN_MAP, 32'h00FF_00FF);
    add_req(KIND_SET, 8'd0, 32'hFFFF_FFFF);
    add_req(KIND_SET, 8'd255, 32'd65535);

    // Hold reset, then release it at a falling edge.
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part: drain before every register write so the block is idle.
    foreach (script_rows[i]) begin
      if (script_rows[i].is_reg) begin
        settle_outputs();
        write_reg(script_rows[i].reg_idx, script_rows[i].reg_data);
      end else begin
        send_word(script_rows[i].word, script_rows[i].known, script_rows[i].want);
      end
    end

    // Random phases: fresh settings each time, channel state carried over so
    // that a top change after a write is seen by the following requests.
    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      settle_outputs();

      case (ph)
        0: begin res_new = RES_MIN; top_new = 15'd3; end
        1: begin res_new = RES_MAX; top_new = 15'd32767; end
        2: begin res_new = 5'd0;    top_new = 15'd0; end
        3: begin res_new = 5'd31;   top_new = $urandom_range(1, 2); end
        default: begin
          res_new = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
          case ($urandom_range(0, 5))
            0: top_new = $urandom_range(0, 2);
            1: top_new = $urandom_range(3, 20);
            2: top_new = 15'd32767;
            3: top_new = $urandom_range(3, 32767);
            4: top_new = TOP_RESET;
            default: top_new = $urandom_range(100, 2000);
          endcase
        end
      endcase

      // Pin maps: the reset one, a narrow pool that breeds duplicates,
      // one pin everywhere, or anything at all.
      case ((ph == 0) ? 0 : $urandom_range(0, 3))
        0: map_new = MAP_RESET;
        1: map_new = {8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)),
                      8'($urandom_range(0, 15)), 8'($urandom_range(0, 15))};
        2: map_new = {4{8'($urandom_range(0, 255))}};
        default: map_new = $urandom;
      endcase

      write_reg(REG_WRITE_RES, {27'd0, res_new});
      write_reg(REG_COUNTER_TOP, {17'd0, top_new});
      write_reg(REG_PIN_MAP, map_new);

      // Phase zero runs with no idling on either side.
      stall_mode = stall_mode_e'(ph % 4);
      gap_max    = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 4 : 12;
      burst_left = 0;

      for (int unsigned n = 0; n < WORDS_PER_PHASE; n++) begin
        // Midway through each phase, hold off until the block has drained.
        if (n == WORDS_PER_PHASE / 2) settle_outputs();

        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap        = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
          if (gap != 0) begin
            in_valid_i = 1'b0;
            repeat (gap) @(negedge clk_i);
          end
        end
        burst_left--;

        // Mostly pins the map owns, now and then any pin.
        if ($urandom_range(0, 3) != 0) pin = reg_map[8*$urandom_range(0, 3) +: 8];
        else pin = $urandom_range(0, 255);

        full = full_scale(reg_res);
        case ($urandom_range(0, 8))
          0: duty = 32'd0;
          1: duty = full;
          2: duty = full / 2;
          3: duty = full / 2 + 1;
          4: duty = $urandom_range(1, full);
          5: duty = $urandom;
          6: duty = 32'd0 - $urandom_range(1, 1000);
          7: duty = full + $urandom_range(1, 100);
          default: duty = $urandom_range(0, full);
        endcase

        w.kind       = ($urandom_range(0, 3) == 0) ? KIND_DISABLE : KIND_SET;
        w.pin_number = pin;
        w.duty_value = duty;
        send_word(w, 1'b0, '0);
      end
    end

    // Drain, then give the block time to show any stray result word.
    settle_outputs();
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("Run covered %0d requests (%0d disables) across %0d register writes",
             words_sent, disables_sent, regs_written);
    $display("Checked %0d result words: %0d digital writes, %0d with the generator running",
             results_checked, digital_seen, running_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches in total", errors);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
